// ===== design/tc2t_pkg.sv =====
// Package for the thermocouple code to temperature converter.
// Holds fixed field widths, fixed-point constants, the inverse polynomial
// coefficient tables and the accumulator payload type. No dependencies.
package tc2t_pkg;

    // Port field widths
    localparam int ADC_W  = 10;
    localparam int NV_W   = 18;
    localparam int TEMP_W = 12;

    // Code times factor, below 2^28
    localparam int PROD_W = ADC_W + NV_W;

    // Constant divider by 15625 (the 1e6 scaling with the 2^6 factored out)
    localparam int DIV_N_W  = 32;
    localparam int RECIP_W  = 19;
    localparam int QUO_W    = 19;
    localparam int REM_W    = 14;
    localparam int DIFF_W   = 15;
    localparam int SIDE_W   = 15;
    localparam int QLO_W    = 18;
    localparam logic [REM_W-1:0]   DIVISOR   = 14'd15625;
    localparam logic [RECIP_W-1:0] RECIP     = 19'd274877;  // floor(2^32 / 15625)
    localparam logic [QLO_W-1:0]   ROUND_OFS = 18'd7812;    // half LSB of V, prescaled

    // Thermocouple voltage in Q.24 millivolts
    localparam int V_W = SIDE_W + QLO_W;
    localparam logic [V_W-1:0] RANGE_SPLIT_Q24 = 33'd346348848;

    // Accumulator, sign and magnitude, magnitude limited to 2^62
    localparam int MAG_W = 63;
    localparam int ACC_W = MAG_W + 2;
    localparam logic [MAG_W-1:0] ACC_LIMIT  = 63'h4000_0000_0000_0000;
    localparam logic [23:0]      ROUND_Q24  = 24'h80_0000;
    localparam logic signed [ACC_W-1:0] ROUND_HALF = 65'sh80_0000_0000;

    // Coefficients, signed Q.40
    localparam int COEF_W = 49;
    localparam int COEF_N = 10;
    localparam logic signed [COEF_W-1:0] LOW_COEF [COEF_N] = '{
        49'sd0,
        49'sd27579654890901,
        49'sd86422779426,
        -49'sd275222164035,
        49'sd91427360531,
        -49'sd13502376623,
        49'sd1077965158,
        -49'sd48521778,
        49'sd1162991,
        -49'sd11575
    };
    localparam logic signed [COEF_W-1:0] HIGH_COEF [COEF_N] = '{
        -49'sd144922009708318,
        49'sd53108852537394,
        -49'sd1809830224180,
        49'sd60085352772,
        -49'sd1061107336,
        49'sd9678114,
        -49'sd34204,
        49'sd0,
        49'sd0,
        49'sd0
    };

    // Output range
    localparam int TEMP_MAX = 2047;
    localparam int TEMP_MIN = -256;
    localparam logic [NV_W-1:0] NV_RESET = 18'd48519;

    // Accumulator payload travelling down the Horner chain
    typedef struct packed {
        logic [V_W-1:0]   v;
        logic             rng;
        logic             neg;
        logic [MAG_W-1:0] mag;
    } t_acc;

    function automatic logic signed [COEF_W-1:0] f_coef(input logic rng,
                                                        input logic [3:0] idx);
        logic signed [COEF_W-1:0] c;
        c = rng ? HIGH_COEF[idx] : LOW_COEF[idx];
        return c;
    endfunction

endpackage

// ===== design/tc2t_div.sv =====
// Three-stage divider of a 32-bit value by the constant 15625.
// Reciprocal multiply, multiply back, one correction step.
// Depends on tc2t_pkg.
module tc2t_div (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    output logic                        o_stall,
    input  logic [tc2t_pkg::DIV_N_W-1:0] i_num,
    input  logic [tc2t_pkg::SIDE_W-1:0]  i_side,
    output logic                        o_valid,
    input  logic                        i_stall,
    output logic [tc2t_pkg::QUO_W-1:0]   o_quo,
    output logic [tc2t_pkg::REM_W-1:0]   o_rem,
    output logic [tc2t_pkg::SIDE_W-1:0]  o_side
);
    import tc2t_pkg::*;

    localparam int RP_W = DIV_N_W + RECIP_W;
    localparam int BK_W = QUO_W + REM_W + 1;

    logic                r1_vld, r2_vld, r3_vld;
    logic [DIV_N_W-1:0]  r1_num;
    logic [QUO_W-1:0]    r1_qe, r2_qe, r3_quo;
    logic [SIDE_W-1:0]   r1_side, r2_side, r3_side;
    logic [DIFF_W-1:0]   r2_diff;
    logic [REM_W-1:0]    r3_rem;

    logic                en1, en2, en3;
    logic [RP_W-1:0]     w_rp;
    logic [BK_W-1:0]     w_back;
    logic [DIV_N_W-1:0]  w_diff;
    logic [QUO_W-1:0]    n1_qe, n3_quo;
    logic [DIFF_W-1:0]   n2_diff;
    logic [REM_W-1:0]    n3_rem;

    assign en3     = !r3_vld || !i_stall;
    assign en2     = !r2_vld || en3;
    assign en1     = !r1_vld || en2;
    assign o_stall = !en1;

    always_comb begin
        // Estimate is low by at most one
        w_rp   = RP_W'(i_num) * RP_W'(RECIP);
        n1_qe  = w_rp[RP_W-1:DIV_N_W];
        w_back = BK_W'(r1_qe) * BK_W'(DIVISOR);
        w_diff = r1_num - w_back[DIV_N_W-1:0];
        n2_diff = w_diff[DIFF_W-1:0];
        if (r2_diff >= DIFF_W'(DIVISOR)) begin
            n3_quo = r2_qe + QUO_W'(1);
            n3_rem = REM_W'(r2_diff - DIFF_W'(DIVISOR));
        end else begin
            n3_quo = r2_qe;
            n3_rem = r2_diff[REM_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_vld <= 1'b0;
            r2_vld <= 1'b0;
            r3_vld <= 1'b0;
        end else begin
            if (en1) r1_vld <= i_valid;
            if (en2) r2_vld <= r1_vld;
            if (en3) r3_vld <= r2_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en1) begin
            r1_num  <= i_num;
            r1_qe   <= n1_qe;
            r1_side <= i_side;
        end
        if (en2) begin
            r2_qe   <= r1_qe;
            r2_diff <= n2_diff;
            r2_side <= r1_side;
        end
        if (en3) begin
            r3_quo  <= n3_quo;
            r3_rem  <= n3_rem;
            r3_side <= r2_side;
        end
    end

    assign o_valid = r3_vld;
    assign o_quo   = r3_quo;
    assign o_rem   = r3_rem;
    assign o_side  = r3_side;

`ifndef SYNTH
    a_rem_below_divisor: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r3_vld |-> (r3_rem < DIVISOR))
        else $error("divider remainder not reduced");
    a_diff_one_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r2_vld |-> (r2_diff < (DIFF_W'(DIVISOR) << 1)))
        else $error("reciprocal estimate off by more than one");
    a_empty_never_stalls: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!r1_vld && !r2_vld && !r3_vld) |-> !o_stall)
        else $error("empty divider stalls upstream");
`endif

endmodule

// ===== design/tc2t_horner.sv =====
// One Horner step: acc = clamp(round(acc * V / 2^24) + coef), three stages.
// Accumulator travels as sign and magnitude. Depends on tc2t_pkg.
module tc2t_horner #(
    parameter int COEF_IDX = 0
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    output logic            o_stall,
    input  tc2t_pkg::t_acc  i_acc,
    output logic            o_valid,
    input  logic            i_stall,
    output tc2t_pkg::t_acc  o_acc
);
    import tc2t_pkg::*;

    localparam int PLO_W  = 32 + V_W;
    localparam int PHI_W  = (MAG_W - 32) + V_W;
    localparam int FULL_W = PHI_W + 32;
    localparam int RND_W  = FULL_W - 24;

    typedef struct packed {
        logic [V_W-1:0]   v;
        logic             rng;
        logic             neg;
        logic [PLO_W-1:0] plo;
        logic [PHI_W-1:0] phi;
    } t_prod;

    logic      r1_vld, r2_vld, r3_vld;
    t_prod     r1, n1;
    t_acc      r2, n2, r3, n3;
    logic      en1, en2, en3;

    logic [FULL_W-1:0]        w_full;
    logic [RND_W-1:0]         w_rnd;
    logic signed [COEF_W-1:0] w_coef;
    logic signed [ACC_W-1:0]  w_c, w_nc, w_m, w_s, w_ns, w_lim;

    assign en3     = !r3_vld || !i_stall;
    assign en2     = !r2_vld || en3;
    assign en1     = !r1_vld || en2;
    assign o_stall = !en1;

    always_comb begin
        // Partial products of the magnitude halves
        n1.v   = i_acc.v;
        n1.rng = i_acc.rng;
        n1.neg = i_acc.neg;
        n1.plo = PLO_W'(i_acc.mag[31:0]) * PLO_W'(i_acc.v);
        n1.phi = PHI_W'(i_acc.mag[MAG_W-1:32]) * PHI_W'(i_acc.v);

        // Combine, round half up, drop 24 fraction bits, limit
        w_full = {r1.phi, 32'b0} + FULL_W'(r1.plo) + FULL_W'(ROUND_Q24);
        w_rnd  = w_full[FULL_W-1:24];
        n2.v   = r1.v;
        n2.rng = r1.rng;
        n2.neg = r1.neg;
        n2.mag = (w_rnd > RND_W'(ACC_LIMIT)) ? ACC_LIMIT : w_rnd[MAG_W-1:0];

        // Add coefficient, form both signs in parallel, limit
        w_coef = f_coef(r2.rng, 4'(COEF_IDX));
        w_c    = ACC_W'(w_coef);
        w_nc   = -w_c;
        w_m    = signed'({2'b00, r2.mag});
        w_lim  = signed'({2'b00, ACC_LIMIT});
        w_s    = r2.neg ? (w_c - w_m) : (w_c + w_m);
        w_ns   = r2.neg ? (w_m - w_c) : (w_nc - w_m);
        n3.v   = r2.v;
        n3.rng = r2.rng;
        if (w_s[ACC_W-1]) begin
            n3.neg = 1'b1;
            n3.mag = (w_ns > w_lim) ? ACC_LIMIT : w_ns[MAG_W-1:0];
        end else begin
            n3.neg = 1'b0;
            n3.mag = (w_s > w_lim) ? ACC_LIMIT : w_s[MAG_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_vld <= 1'b0;
            r2_vld <= 1'b0;
            r3_vld <= 1'b0;
        end else begin
            if (en1) r1_vld <= i_valid;
            if (en2) r2_vld <= r1_vld;
            if (en3) r3_vld <= r2_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en1) r1 <= n1;
        if (en2) r2 <= n2;
        if (en3) r3 <= n3;
    end

    assign o_valid = r3_vld;
    assign o_acc   = r3;

`ifndef SYNTH
    a_product_limited: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r2_vld |-> (r2.mag <= ACC_LIMIT))
        else $error("rounded product above accumulator limit");
    a_sum_limited: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r3_vld |-> (r3.mag <= ACC_LIMIT))
        else $error("accumulator above limit after coefficient add");
    a_range_kept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r3_vld && en3 && r2_vld) |=> (r3.rng == $past(r2.rng)))
        else $error("range select lost between stages");
`endif

endmodule

// ===== design/thermocouple_code_to_temperature.sv =====
// Path from accepted code to result: T0, both dividers, T2, the Horner chain, F1 and the output register.
// Throughput: one transaction per cycle while the output is not stalled; each Horner term has three stages of its own.
// Rate is set by the Horner chain: a 32x33 and a 31x33 partial product per term, then round, then add.
// Reset (i_rst_n low at a clock edge) empties the pipeline and sets the factor to 48519.
// A stalled output holds; empty stages ahead of it keep taking new codes.
// Top level: thermocouple code to temperature, depends on tc2t_pkg, tc2t_div, tc2t_horner.
module thermocouple_code_to_temperature #(
    parameter int ADC_CODES  = 1024,
    parameter int POLY_TERMS = 10
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // configuration
    input  logic                                i_cfg_wr_en,
    input  logic [tc2t_pkg::NV_W-1:0]           i_cfg_wr_data,
    // input channel
    input  logic                                i_valid,
    output logic                                o_stall,
    input  logic [tc2t_pkg::ADC_W-1:0]          i_adc_code,
    // output channel
    output logic                                o_valid,
    input  logic                                i_stall,
    output logic signed [tc2t_pkg::TEMP_W-1:0]  o_temperature_c,
    output logic                                o_saturated
);
    import tc2t_pkg::*;

    // Codes above the converter range clip to its top code
    localparam int CODE_LIM = (ADC_CODES - 1 > (1 << ADC_W) - 1) ?
                              (1 << ADC_W) - 1 : ADC_CODES - 1;
    localparam logic [ADC_W-1:0] CODE_MAX = ADC_W'(CODE_LIM);
    localparam int DEG_W = ACC_W - 40;

    // Configuration register
    logic [NV_W-1:0]         r_nv_per_code;

    // Stage T0: code times factor
    logic                    r_t0_vld;
    logic [PROD_W-1:0]       r_t0_prod;
    logic [ADC_W-1:0]        w_code;
    logic [PROD_W-1:0]       n_t0_prod;
    logic                    en_t0;

    // Two constant divisions give V in Q.24 millivolts
    logic                    w_d1_vld, w_d1_stall, w_d2_vld, w_d2_stall;
    logic                    w_d2_stall_up;
    logic [QUO_W-1:0]        w_d1_quo, w_d2_quo;
    logic [REM_W-1:0]        w_d1_rem;
    logic [SIDE_W-1:0]       w_d2_side;

    // Stage T2: range select and first coefficient
    logic                    r_t2_vld;
    t_acc                    r_t2, n_t2;
    logic                    en_t2;
    logic signed [COEF_W-1:0] w_top_coef;
    logic signed [MAG_W:0]   w_top_ext, w_top_abs;

    // Horner chain
    logic                    w_h_vld   [POLY_TERMS];
    logic                    w_h_stall [POLY_TERMS];
    t_acc                    w_h       [POLY_TERMS];

    // Stage F1: two's complement plus one half degree
    logic                    r_f1_vld;
    logic signed [ACC_W-1:0] r_f1_t, n_f1_t, w_f1_m;
    logic                    en_f1;

    // Stage F2: output register
    logic                    r_o_vld;
    logic signed [TEMP_W-1:0] r_o_temp, n_o_temp;
    logic                    r_o_sat, n_o_sat;
    logic signed [DEG_W-1:0] w_deg;
    logic                    en_o;

    // Stall chain: a stage advances when empty or when the next one advances
    assign en_o    = !r_o_vld || !i_stall;
    assign en_f1   = !r_f1_vld || en_o;
    assign w_h_stall[POLY_TERMS-1] = !en_f1;
    assign en_t2   = !r_t2_vld || !w_h_stall[0];
    assign w_d2_stall = !en_t2;
    assign en_t0   = !r_t0_vld || !w_d1_stall;
    assign o_stall = !en_t0;

    // Write the factor; the user must write it only while the block is idle, the block itself does not enforce this
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_nv_per_code <= NV_RESET;
        end else if (i_cfg_wr_en) begin
            r_nv_per_code <= i_cfg_wr_data;
        end
    end

    always_comb begin
        w_code    = (i_adc_code > CODE_MAX) ? CODE_MAX : i_adc_code;
        n_t0_prod = PROD_W'(w_code) * PROD_W'(r_nv_per_code);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_t0_vld <= 1'b0;
        end else if (en_t0) begin
            r_t0_vld <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en_t0) r_t0_prod <= n_t0_prod;
    end

    // V = floor((prod * 2^18 + 7812) / 15625). Split prod = q*15625 + r, then
    // V = q * 2^18 + floor((r * 2^18 + 7812) / 15625); the second part stays below 2^18.
    tc2t_div u_div_hi (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_t0_vld),
        .o_stall (w_d1_stall),
        .i_num   (DIV_N_W'(r_t0_prod)),
        .i_side  ({SIDE_W{1'b0}}),
        .o_valid (w_d1_vld),
        .i_stall (w_d2_stall_up),
        .o_quo   (w_d1_quo),
        .o_rem   (w_d1_rem),
        .o_side  ()
    );

    tc2t_div u_div_lo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_d1_vld),
        .o_stall (w_d2_stall_up),
        .i_num   ({w_d1_rem, ROUND_OFS}),
        .i_side  (w_d1_quo[SIDE_W-1:0]),
        .o_valid (w_d2_vld),
        .i_stall (w_d2_stall),
        .o_quo   (w_d2_quo),
        .o_rem   (),
        .o_side  (w_d2_side)
    );

    // Pick the range and load the top coefficient as sign and magnitude
    always_comb begin
        n_t2.v     = {w_d2_side, w_d2_quo[QLO_W-1:0]};
        n_t2.rng   = (n_t2.v >= RANGE_SPLIT_Q24);
        w_top_coef = f_coef(n_t2.rng, 4'(POLY_TERMS - 1));
        w_top_ext  = (MAG_W + 1)'(w_top_coef);
        n_t2.neg   = w_top_coef[COEF_W-1];
        w_top_abs  = n_t2.neg ? -w_top_ext : w_top_ext;
        n_t2.mag   = w_top_abs[MAG_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_t2_vld <= 1'b0;
        end else if (en_t2) begin
            r_t2_vld <= w_d2_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en_t2) r_t2 <= n_t2;
    end

    assign w_h_vld[0] = r_t2_vld;
    assign w_h[0]     = r_t2;

    // One step per remaining coefficient, highest order first
    for (genvar j = 0; j < POLY_TERMS - 1; j++) begin : g_step
        tc2t_horner #(
            .COEF_IDX (POLY_TERMS - 2 - j)
        ) u_step (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (w_h_vld[j]),
            .o_stall (w_h_stall[j]),
            .i_acc   (w_h[j]),
            .o_valid (w_h_vld[j+1]),
            .i_stall (w_h_stall[j+1]),
            .o_acc   (w_h[j+1])
        );
    end

    // Signed accumulator plus one half degree, in one add or subtract
    always_comb begin
        w_f1_m = signed'({2'b00, w_h[POLY_TERMS-1].mag});
        n_f1_t = w_h[POLY_TERMS-1].neg ? (ROUND_HALF - w_f1_m) : (w_f1_m + ROUND_HALF);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_f1_vld <= 1'b0;
        end else if (en_f1) begin
            r_f1_vld <= w_h_vld[POLY_TERMS-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en_f1) r_f1_t <= n_f1_t;
    end

    // Floor to whole degrees and clip to the output range
    always_comb begin
        w_deg = r_f1_t[ACC_W-1:40];
        if (w_deg > DEG_W'(TEMP_MAX)) begin
            n_o_temp = TEMP_W'(TEMP_MAX);
            n_o_sat  = 1'b1;
        end else if (w_deg < DEG_W'(TEMP_MIN)) begin
            n_o_temp = TEMP_W'(TEMP_MIN);
            n_o_sat  = 1'b1;
        end else begin
            n_o_temp = w_deg[TEMP_W-1:0];
            n_o_sat  = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_vld <= 1'b0;
        end else if (en_o) begin
            r_o_vld <= r_f1_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en_o) begin
            r_o_temp <= n_o_temp;
            r_o_sat  <= n_o_sat;
        end
    end

    assign o_valid         = r_o_vld;
    assign o_temperature_c = r_o_temp;
    assign o_saturated     = r_o_sat;

`ifndef SYNTH
    a_sat_at_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_saturated) |->
            (o_temperature_c == TEMP_W'(TEMP_MAX) || o_temperature_c == TEMP_W'(TEMP_MIN)))
        else $error("saturated flag without a clipped temperature");
    a_idle_out_no_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_valid |-> !o_stall)
        else $error("input stalled while output register is empty");
    a_f1_feeds_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_f1_vld && en_o) |=> o_valid)
        else $error("rounded transaction dropped before the output register");
`endif

endmodule
